@@ rtl/ctt_pkg.sv @@
// Shared types, constants and character class helpers for the config text tokenizer.
package ctt_pkg;

  // Longest token text that is kept; longer tokens end as invalid
  localparam int MaxText = 64;
  localparam int CntW    = $clog2(MaxText + 1);

  // Result queue between the lexer and the output side
  localparam int QDepth = 4;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Character codes
  localparam logic [7:0] ChHash  = 8'h23;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChE     = 8'h65;
  localparam logic [7:0] ChUnder = 8'h5f;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChEq    = 8'h3d;
  localparam logic [7:0] ChSemi  = 8'h3b;
  localparam logic [7:0] ChLbr   = 8'h7b;
  localparam logic [7:0] ChRbr   = 8'h7d;
  localparam logic [7:0] ChNul   = 8'h00;

  typedef enum logic [3:0] {
    TokInt     = 4'd0,
    TokFloat   = 4'd1,
    TokSymbol  = 4'd2,
    TokString  = 4'd3,
    TokEqual   = 4'd4,
    TokSemi    = 4'd5,
    TokLbrace  = 4'd6,
    TokRbrace  = 4'd7,
    TokEof     = 4'd8,
    TokInvalid = 4'd9
  } tok_type_e;

  typedef enum logic [7:0] {
    ModeIdle    = 8'b0000_0001,
    ModeComment = 8'b0000_0010,
    ModeNumber  = 8'b0000_0100,
    ModeSymbol  = 8'b0000_1000,
    ModeString  = 8'b0001_0000,
    ModeOnum    = 8'b0010_0000,
    ModeOsym    = 8'b0100_0000,
    ModeOstr    = 8'b1000_0000
  } lex_mode_e;

  // One output result
  typedef struct packed {
    logic       is_token;
    logic [7:0] text_char;
    tok_type_e  token_type;
    logic [6:0] token_length;
  } result_t;

  // One queue entry: the one or two results caused by one item
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  function automatic logic is_space(logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0d]};
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return c inside {[8'h41:8'h5a], [8'h61:8'h7a]};
  endfunction

  function automatic logic is_numch(logic [7:0] c);
    return is_digit(c) || (c == ChDot) || (c == ChE) || (c == ChMinus);
  endfunction

  function automatic logic is_symch(logic [7:0] c);
    return is_alpha(c) || is_digit(c) || (c == ChUnder);
  endfunction

  // Low seven bits of a text count
  function automatic logic [6:0] len7(logic [CntW-1:0] n);
    logic [CntW+6:0] w;
    w = {7'b0, n};
    return w[6:0];
  endfunction

  function automatic result_t char_res(logic [7:0] c);
    result_t r;
    r.is_token     = 1'b0;
    r.text_char    = c;
    r.token_type   = TokInt;
    r.token_length = 7'd0;
    return r;
  endfunction

  function automatic result_t tok_res(tok_type_e t, logic [CntW-1:0] n);
    result_t r;
    r.is_token     = 1'b1;
    r.text_char    = ChNul;
    r.token_type   = t;
    r.token_length = len7(n);
    return r;
  endfunction

endpackage

@@ rtl/ctt_front.sv @@
// Lexer front end: takes characters, tracks the lexing mode, builds result entries.
module ctt_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic [7:0]      ch_i,
  input  logic            at_end_i,
  input  logic            q_full_i,
  output logic            push_o,
  output ctt_pkg::entry_t entry_o
);

  typedef struct packed {
    logic                    emit;
    ctt_pkg::result_t        res;
    ctt_pkg::lex_mode_e      mode;
    logic                    flt;
    logic [ctt_pkg::CntW-1:0] cnt;
  } idle_t;

  ctt_pkg::lex_mode_e       mode_q, mode_d;
  logic                     flt_q, flt_d;
  logic [ctt_pkg::CntW-1:0] cnt_q, cnt_d;

  idle_t            idle_r;
  logic             tok_v, sec_v;
  ctt_pkg::result_t tok_r, sec_r;
  logic             accept;

  // Handling of a character seen in idle mode
  function automatic idle_t idle_char(logic [7:0] c);
    idle_t o;
    o.emit = 1'b0;
    o.res  = ctt_pkg::char_res(c);
    o.mode = ctt_pkg::ModeIdle;
    o.flt  = 1'b0;
    o.cnt  = '0;
    if (ctt_pkg::is_space(c)) begin
      o.emit = 1'b0;
    end else if (c == ctt_pkg::ChHash) begin
      o.mode = ctt_pkg::ModeComment;
    end else if (ctt_pkg::is_numch(c) && !ctt_pkg::is_alpha(c)) begin
      o.mode = ctt_pkg::ModeNumber;
      o.flt  = !ctt_pkg::is_digit(c);
      o.cnt  = ctt_pkg::CntW'(1);
      o.emit = 1'b1;
    end else if (ctt_pkg::is_alpha(c)) begin
      o.mode = ctt_pkg::ModeSymbol;
      o.cnt  = ctt_pkg::CntW'(1);
      o.emit = 1'b1;
    end else if (c == ctt_pkg::ChQuote) begin
      o.mode = ctt_pkg::ModeString;
    end else if (c == ctt_pkg::ChEq) begin
      o.emit = 1'b1;
      o.res  = ctt_pkg::tok_res(ctt_pkg::TokEqual, '0);
    end else if (c == ctt_pkg::ChSemi) begin
      o.emit = 1'b1;
      o.res  = ctt_pkg::tok_res(ctt_pkg::TokSemi, '0);
    end else if (c == ctt_pkg::ChLbr) begin
      o.emit = 1'b1;
      o.res  = ctt_pkg::tok_res(ctt_pkg::TokLbrace, '0);
    end else if (c == ctt_pkg::ChRbr) begin
      o.emit = 1'b1;
      o.res  = ctt_pkg::tok_res(ctt_pkg::TokRbrace, '0);
    end else begin
      // character that starts no token
      o.emit = 1'b1;
      o.res  = ctt_pkg::tok_res(ctt_pkg::TokInvalid, '0);
    end
    return o;
  endfunction

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // Next mode and the results of this item: an ending token first, then a second result
  always_comb begin
    idle_r = idle_char(ch_i);
    mode_d = mode_q;
    flt_d  = flt_q;
    cnt_d  = cnt_q;
    tok_v  = 1'b0;
    tok_r  = ctt_pkg::tok_res(ctt_pkg::TokInvalid, cnt_q);
    sec_v  = 1'b0;
    sec_r  = ctt_pkg::char_res(ch_i);
    if (at_end_i) begin
      case (mode_q)
        ctt_pkg::ModeNumber: begin
          tok_v = 1'b1;
          tok_r = ctt_pkg::tok_res(flt_q ? ctt_pkg::TokFloat : ctt_pkg::TokInt, cnt_q);
        end
        ctt_pkg::ModeSymbol, ctt_pkg::ModeString, ctt_pkg::ModeOnum,
        ctt_pkg::ModeOsym, ctt_pkg::ModeOstr: begin
          tok_v = 1'b1;
        end
        default: begin
          tok_v = 1'b0;
        end
      endcase
      sec_v  = 1'b1;
      sec_r  = ctt_pkg::tok_res(ctt_pkg::TokEof, '0);
      mode_d = ctt_pkg::ModeIdle;
      flt_d  = 1'b0;
      cnt_d  = '0;
    end else begin
      case (mode_q)
        ctt_pkg::ModeComment: begin
          if (ch_i == ctt_pkg::ChLf) mode_d = ctt_pkg::ModeIdle;
        end
        ctt_pkg::ModeNumber, ctt_pkg::ModeOnum: begin
          if (ctt_pkg::is_numch(ch_i)) begin
            if (!ctt_pkg::is_digit(ch_i)) flt_d = 1'b1;
            if (mode_q == ctt_pkg::ModeNumber) begin
              if (cnt_q < ctt_pkg::CntW'(ctt_pkg::MaxText)) begin
                cnt_d = cnt_q + ctt_pkg::CntW'(1);
                sec_v = 1'b1;
              end else begin
                mode_d = ctt_pkg::ModeOnum;
              end
            end
          end else begin
            tok_v = 1'b1;
            if (mode_q == ctt_pkg::ModeNumber) begin
              tok_r = ctt_pkg::tok_res(flt_q ? ctt_pkg::TokFloat : ctt_pkg::TokInt, cnt_q);
            end
            mode_d = idle_r.mode;
            flt_d  = idle_r.flt;
            cnt_d  = idle_r.cnt;
            sec_v  = idle_r.emit;
            sec_r  = idle_r.res;
          end
        end
        ctt_pkg::ModeSymbol, ctt_pkg::ModeOsym: begin
          if (ctt_pkg::is_space(ch_i)) begin
            tok_v = 1'b1;
            if (mode_q == ctt_pkg::ModeSymbol) begin
              tok_r = ctt_pkg::tok_res(ctt_pkg::TokSymbol, cnt_q);
            end
            mode_d = ctt_pkg::ModeIdle;
            flt_d  = 1'b0;
            cnt_d  = '0;
          end else if (ctt_pkg::is_symch(ch_i)) begin
            if (mode_q == ctt_pkg::ModeSymbol) begin
              if (cnt_q < ctt_pkg::CntW'(ctt_pkg::MaxText)) begin
                cnt_d = cnt_q + ctt_pkg::CntW'(1);
                sec_v = 1'b1;
              end else begin
                mode_d = ctt_pkg::ModeOsym;
              end
            end
          end else begin
            // bad symbol character: invalid token, then the character anew
            tok_v  = 1'b1;
            mode_d = idle_r.mode;
            flt_d  = idle_r.flt;
            cnt_d  = idle_r.cnt;
            sec_v  = idle_r.emit;
            sec_r  = idle_r.res;
          end
        end
        ctt_pkg::ModeString, ctt_pkg::ModeOstr: begin
          if (ch_i == ctt_pkg::ChQuote) begin
            tok_v = 1'b1;
            if (mode_q == ctt_pkg::ModeString) begin
              tok_r = ctt_pkg::tok_res(ctt_pkg::TokString, cnt_q);
            end
            mode_d = ctt_pkg::ModeIdle;
            flt_d  = 1'b0;
            cnt_d  = '0;
          end else if (mode_q == ctt_pkg::ModeString) begin
            if (cnt_q < ctt_pkg::CntW'(ctt_pkg::MaxText)) begin
              cnt_d = cnt_q + ctt_pkg::CntW'(1);
              sec_v = 1'b1;
            end else begin
              mode_d = ctt_pkg::ModeOstr;
            end
          end
        end
        default: begin
          mode_d = idle_r.mode;
          flt_d  = idle_r.flt;
          cnt_d  = idle_r.cnt;
          sec_v  = idle_r.emit;
          sec_r  = idle_r.res;
        end
      endcase
    end
  end

  // Pack the results into one queue entry
  always_comb begin
    entry_o.two = tok_v && sec_v;
    entry_o.r0  = tok_v ? tok_r : sec_r;
    entry_o.r1  = sec_r;
  end

  assign push_o = accept && (tok_v || sec_v);

  // Lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ctt_pkg::ModeIdle;
      flt_q  <= 1'b0;
      cnt_q  <= '0;
    end else if (accept) begin
      mode_q <= mode_d;
      flt_q  <= flt_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

@@ rtl/ctt_fifo.sv @@
// Short entry queue between the lexer front end and the output side.
module ctt_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ctt_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output ctt_pkg::entry_t head_o
);

  ctt_pkg::entry_t           mem_q [ctt_pkg::QDepth];
  logic [ctt_pkg::QPtrW-1:0] wr_q, rd_q;
  logic [ctt_pkg::QCntW-1:0] cnt_q;
  logic                      do_push, do_pop;

  assign full_o       = (cnt_q == ctt_pkg::QCntW'(ctt_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = pop_i && head_valid_o;

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= entry_i;
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == ctt_pkg::QPtrW'(ctt_pkg::QDepth - 1)) ? '0 : wr_q + ctt_pkg::QPtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == ctt_pkg::QPtrW'(ctt_pkg::QDepth - 1)) ? '0 : rd_q + ctt_pkg::QPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + ctt_pkg::QCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - ctt_pkg::QCntW'(1);
      end
    end
  end

endmodule

@@ rtl/ctt_back.sv @@
// Output side: hands out the results of each queued entry one at a time.
module ctt_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  ctt_pkg::entry_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic            is_token_o,
  output logic [7:0]      text_char_o,
  output logic [3:0]      token_type_o,
  output logic [6:0]      token_length_o,
  output logic            last_o
);

  logic             sub_q;
  logic             take;
  ctt_pkg::result_t res;

  assign res            = sub_q ? head_i.r1 : head_i.r0;
  assign last_o         = sub_q || !head_i.two;
  assign out_valid_o    = head_valid_i;
  assign is_token_o     = res.is_token;
  assign text_char_o    = res.text_char;
  assign token_type_o   = res.token_type;
  assign token_length_o = res.token_length;

  assign take  = head_valid_i && !out_stall_i;
  assign pop_o = take && last_o;

  // Which result of the head entry is on the port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= 1'b0;
    end else if (take) begin
      sub_q <= !last_o;
    end
  end

endmodule

@@ rtl/config_text_tokenizer.sv @@
// A result is written into the result queue when the item that causes it is accepted.
// Throughput: one character item per cycle into the lexer unless the queue is full;
// one result per cycle out unless the output stalls, two results of an item in turn.
// A four-entry result queue lets the lexer run ahead of a stalled or busy output side.
// Reset: asynchronous, active low; lexer returns to idle, queue empties.
module config_text_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] ch_i,
  input  logic       at_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       is_token_o,
  output logic [7:0] text_char_o,
  output logic [3:0] token_type_o,
  output logic [6:0] token_length_o,
  output logic       last_o
);

  logic            push, full, pop, head_valid;
  ctt_pkg::entry_t entry, head;

  ctt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .ch_i       (ch_i),
    .at_end_i   (at_end_i),
    .q_full_i   (full),
    .push_o     (push),
    .entry_o    (entry)
  );

  ctt_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .entry_i      (entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  ctt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_i         (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .is_token_o     (is_token_o),
    .text_char_o    (text_char_o),
    .token_type_o   (token_type_o),
    .token_length_o (token_length_o),
    .last_o         (last_o)
  );

endmodule

@@ rtl/ctt_checker.sv @@
// Port-level checks for the config text tokenizer, bound to the top level.
module ctt_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] ch_i,
  input logic       at_end_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic       is_token_o,
  input logic [7:0] text_char_o,
  input logic [3:0] token_type_o,
  input logic [6:0] token_length_o,
  input logic       last_o
);

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(is_token_o) &&
      $stable(text_char_o) && $stable(token_type_o) && $stable(token_length_o) &&
      $stable(last_o))
    else $error("stalled result changed");

  // Text characters carry no type or length
  a_char_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !is_token_o |-> token_type_o == 4'd0 && token_length_o == 7'd0)
    else $error("text character with type or length");

  // Token records carry no character and a legal type
  a_tok_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_token_o |-> text_char_o == 8'd0 &&
      token_type_o <= 4'(ctt_pkg::TokInvalid))
    else $error("bad token record fields");

  // EOF tokens have no text and are the last result of their item
  a_eof_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_token_o && token_type_o == 4'(ctt_pkg::TokEof) |->
      token_length_o == 7'd0 && last_o)
    else $error("EOF record with length or not last");

  // Nothing is offered once reset has been seen at a clock edge
  a_reset: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result offered in reset");

endmodule

bind config_text_tokenizer ctt_checker u_ctt_checker (.*);

@@ tb/tb_top.sv @@
// Self-checking testbench for the config text tokenizer: directed and random input, result check.
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned QuietLimit = 4000;
  localparam int unsigned DrainCycles = 16;
  localparam int unsigned RandomItems = 700;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  typedef struct packed {
    logic               is_token;
    logic [7:0]         text_char;
    ctt_pkg::tok_type_e token_type;
    logic [6:0]         token_length;
    logic               last;
  } lex_res_t;

  // Lexer modes of the predictor; the long variants drop text past the limit
  typedef enum logic [2:0] {
    LxIdle, LxComment, LxNumber, LxSymbol, LxString, LxNumLong, LxSymLong, LxStrLong
  } lx_mode_e;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] ch = 8'h00;
  logic       at_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       is_token;
  logic [7:0] text_char;
  logic [3:0] token_type;
  logic [6:0] token_length;
  logic       last;

  char_item_t  char_q[$];
  lex_res_t    lex_out_q[$];
  int unsigned item_total = 0;
  int unsigned fails = 0;
  int unsigned quiet_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned stall_left = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;

  // Predictor state
  lx_mode_e    lx_mode = LxIdle;
  logic        lx_float = 1'b0;
  int unsigned lx_count = 0;
  lex_res_t    lx_buf[2];
  int unsigned lx_emitted;

  config_text_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .ch_i          (ch),
    .at_end_i      (at_end),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .is_token_o    (is_token),
    .text_char_o   (text_char),
    .token_type_o  (token_type),
    .token_length_o(token_length),
    .last_o        (last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Character classes
  function automatic bit ws_char(logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic bit dig_char(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit let_char(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5a) || (c >= 8'h61 && c <= 8'h7a);
  endfunction

  function automatic bit num_char(logic [7:0] c);
    return dig_char(c) || c == ctt_pkg::ChDot || c == ctt_pkg::ChE || c == ctt_pkg::ChMinus;
  endfunction

  function automatic bit sym_char(logic [7:0] c);
    return let_char(c) || dig_char(c) || c == ctt_pkg::ChUnder;
  endfunction

  function automatic void put_res(logic tok, logic [7:0] c, ctt_pkg::tok_type_e t,
                                  int unsigned n);
    lx_buf[lx_emitted] = '{is_token: tok, text_char: c, token_type: t,
                           token_length: 7'(n), last: 1'b0};
    lx_emitted++;
  endfunction

  // A finished token returns the lexer to idle
  function automatic void put_token(ctt_pkg::tok_type_e t, int unsigned n);
    put_res(1'b1, ctt_pkg::ChNul, t, n);
    lx_mode  = LxIdle;
    lx_float = 1'b0;
    lx_count = 0;
  endfunction

  function automatic void put_text(logic [7:0] c, lx_mode_e long_mode);
    if (lx_count < ctt_pkg::MaxText) begin
      lx_count++;
      put_res(1'b0, c, ctt_pkg::TokInt, 0);
    end else begin
      lx_mode = long_mode;
    end
  endfunction

  // Character seen in idle mode
  function automatic void start_char(logic [7:0] c);
    if (ws_char(c)) return;
    if (c == ctt_pkg::ChHash) begin
      lx_mode = LxComment;
    end else if (num_char(c) && !let_char(c)) begin
      lx_mode  = LxNumber;
      lx_float = !dig_char(c);
      lx_count = 1;
      put_res(1'b0, c, ctt_pkg::TokInt, 0);
    end else if (let_char(c)) begin
      lx_mode  = LxSymbol;
      lx_float = 1'b0;
      lx_count = 1;
      put_res(1'b0, c, ctt_pkg::TokInt, 0);
    end else if (c == ctt_pkg::ChQuote) begin
      lx_mode  = LxString;
      lx_float = 1'b0;
      lx_count = 0;
    end else if (c == ctt_pkg::ChEq) begin
      put_token(ctt_pkg::TokEqual, 0);
    end else if (c == ctt_pkg::ChSemi) begin
      put_token(ctt_pkg::TokSemi, 0);
    end else if (c == ctt_pkg::ChLbr) begin
      put_token(ctt_pkg::TokLbrace, 0);
    end else if (c == ctt_pkg::ChRbr) begin
      put_token(ctt_pkg::TokRbrace, 0);
    end else begin
      put_token(ctt_pkg::TokInvalid, 0);
    end
  endfunction

  // Expected results of one accepted item, appended to lex_out_q
  function automatic void predict_lex(logic [7:0] c, logic fin);
    lx_emitted = 0;
    if (fin) begin
      case (lx_mode)
        LxNumber: put_token(lx_float ? ctt_pkg::TokFloat : ctt_pkg::TokInt, lx_count);
        LxSymbol, LxString, LxNumLong, LxSymLong, LxStrLong:
          put_token(ctt_pkg::TokInvalid, lx_count);
        default: ;
      endcase
      put_token(ctt_pkg::TokEof, 0);
    end else begin
      case (lx_mode)
        LxComment: begin
          if (c == ctt_pkg::ChLf) lx_mode = LxIdle;
        end
        LxNumber, LxNumLong: begin
          if (num_char(c)) begin
            if (!dig_char(c)) lx_float = 1'b1;
            if (lx_mode == LxNumber) put_text(c, LxNumLong);
          end else begin
            if (lx_mode == LxNumber) begin
              put_token(lx_float ? ctt_pkg::TokFloat : ctt_pkg::TokInt, lx_count);
            end else begin
              put_token(ctt_pkg::TokInvalid, lx_count);
            end
            start_char(c);
          end
        end
        LxSymbol, LxSymLong: begin
          if (ws_char(c)) begin
            put_token(lx_mode == LxSymbol ? ctt_pkg::TokSymbol : ctt_pkg::TokInvalid,
                      lx_count);
          end else if (sym_char(c)) begin
            if (lx_mode == LxSymbol) put_text(c, LxSymLong);
          end else begin
            put_token(ctt_pkg::TokInvalid, lx_count);
            start_char(c);
          end
        end
        LxString, LxStrLong: begin
          if (c == ctt_pkg::ChQuote) begin
            put_token(lx_mode == LxString ? ctt_pkg::TokString : ctt_pkg::TokInvalid,
                      lx_count);
          end else if (lx_mode == LxString) begin
            put_text(c, LxStrLong);
          end
        end
        default: begin
          lx_mode = LxIdle;
          start_char(c);
        end
      endcase
    end
    for (int unsigned i = 0; i < lx_emitted; i++) begin
      lx_buf[i].last = (i == lx_emitted - 1);
      lex_out_q.push_back(lx_buf[i]);
    end
  endfunction

  // Gap or stall length: mostly short, a few long, none during calm stretches
  function automatic int unsigned pick_pause(inout bit calm);
    int unsigned r;
    if ($urandom_range(0, 79) == 0) calm = !calm;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  task automatic add_item(logic [7:0] c, logic fin);
    char_q.push_back('{ch: c, fin: fin});
    item_total++;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_item(s[i], 1'b0);
  endtask

  function automatic int unsigned tok_len();
    if ($urandom_range(0, 39) == 0) return $urandom_range(60, 70);
    return $urandom_range(1, 8);
  endfunction

  function automatic logic [7:0] space_byte();
    int unsigned k;
    k = $urandom_range(0, 5);
    return (k == 5) ? 8'h20 : 8'(8'h09 + k);
  endfunction

  // Driver: offers the next item once the current one is taken
  always @(posedge clk_i or negedge rst_ni) begin
    char_item_t it;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      ch       <= 8'h00;
      at_end   <= 1'b0;
    end else begin
      if (in_valid && !in_stall) predict_lex(ch, at_end);
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (char_q.size() > 0) begin
          it = char_q.pop_front();
          in_valid <= 1'b1;
          ch       <= it.ch;
          at_end   <= it.fin;
          gap_left = pick_pause(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result against the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    lex_res_t want;
    if (!rst_ni) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lex_out_q.size() == 0) begin
          $error("unexpected result: is_token %0d text_char %0d token_type %0d length %0d",
                 is_token, text_char, token_type, token_length);
          fails++;
        end else begin
          want = lex_out_q.pop_front();
          check_field("is_token", want.is_token, is_token);
          check_field("text_char", want.text_char, text_char);
          check_field("token_type", want.token_type, token_type);
          check_field("token_length", want.token_length, token_length);
          check_field("last", want.last, last);
        end
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else begin
        out_stall <= 1'b0;
        stall_left = pick_pause(recv_calm);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("tb_top failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned k;
    int unsigned len;
    logic [7:0]  b;

    // Directed: punctuation, string, comment, number ends, unknown bytes, input end
    add_text("k=7;{\"q\"}#c\n");
    add_text("-5");
    add_item(8'hff, 1'b0);
    add_text("a-");
    add_item(ctt_pkg::ChNul, 1'b0);
    add_text("s");
    add_item(8'h00, 1'b1);
    add_text("\"u");
    add_item(8'hff, 1'b1);
    add_text("9");
    add_item(8'h00, 1'b1);

    // Random: mostly well-formed tokens with random content, some noise
    n = item_total + RandomItems;
    while (item_total < n) begin
      case ($urandom_range(0, 15))
        0, 1, 2: begin
          k = $urandom_range(0, 9);
          add_item(k == 7 ? ctt_pkg::ChDot : k == 8 ? ctt_pkg::ChMinus : 8'(8'h30 + k), 1'b0);
          len = tok_len();
          for (int unsigned i = 1; i < len; i++) begin
            k = $urandom_range(0, 19);
            add_item(k == 0 ? ctt_pkg::ChDot : k == 1 ? ctt_pkg::ChE : k == 2 ? ctt_pkg::ChMinus
                     : 8'(8'h30 + $urandom_range(0, 9)), 1'b0);
          end
        end
        3, 4, 5: begin
          k = $urandom_range(0, 51);
          add_item(k < 26 ? 8'(8'h41 + k) : 8'(8'h61 + k - 26), 1'b0);
          len = tok_len();
          for (int unsigned i = 1; i < len; i++) begin
            k = $urandom_range(0, 62);
            if (k < 26) b = 8'(8'h41 + k);
            else if (k < 52) b = 8'(8'h61 + k - 26);
            else if (k < 62) b = 8'(8'h30 + k - 52);
            else b = ctt_pkg::ChUnder;
            add_item(b, 1'b0);
          end
          if ($urandom_range(0, 9) < 7) add_item(space_byte(), 1'b0);
        end
        6, 7: begin
          add_item(ctt_pkg::ChQuote, 1'b0);
          len = tok_len();
          for (int unsigned i = $urandom_range(0, 1); i < len; i++) begin
            b = 8'($urandom_range(0, 254));
            if (b >= ctt_pkg::ChQuote) b++;
            add_item(b, 1'b0);
          end
          if ($urandom_range(0, 9) != 0) add_item(ctt_pkg::ChQuote, 1'b0);
        end
        8, 9: begin
          case ($urandom_range(0, 3))
            0: add_item(ctt_pkg::ChEq, 1'b0);
            1: add_item(ctt_pkg::ChSemi, 1'b0);
            2: add_item(ctt_pkg::ChLbr, 1'b0);
            default: add_item(ctt_pkg::ChRbr, 1'b0);
          endcase
        end
        10: begin
          add_item(ctt_pkg::ChHash, 1'b0);
          len = $urandom_range(0, 6);
          for (int unsigned i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 254));
            if (b >= ctt_pkg::ChLf) b++;
            add_item(b, 1'b0);
          end
          add_item(ctt_pkg::ChLf, 1'b0);
        end
        11: add_item(8'($urandom_range(0, 255)), 1'b0);
        12: add_item(8'($urandom_range(0, 255)), 1'b1);
        default: add_item(space_byte(), 1'b0);
      endcase
    end
    add_item(8'($urandom_range(0, 255)), 1'b1);

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Drain: every item taken and every result seen
    while (char_q.size() != 0 || in_valid || lex_out_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
    if (lex_out_q.size() != 0) begin
      $error("%0d expected results never arrived", lex_out_q.size());
      fails++;
    end
    if (fails == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/ctt_pkg.sv
rtl/ctt_front.sv
rtl/ctt_fifo.sv
rtl/ctt_back.sv
rtl/config_text_tokenizer.sv
rtl/ctt_checker.sv
tb/tb_top.sv
